// File: src/assert_macros.svh
// Assertion shorthands used by cedc_parse_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cedc_pkg.sv
package cedc_pkg;

	localparam logic [7:0] OVF_VALUE_RST = 8'd127;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LX     = 8'h78;
	localparam logic [7:0] CH_UX     = 8'h58;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LN     = 8'h6E;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_LV     = 8'h76;
	localparam logic [7:0] CH_D0     = 8'h30;
	localparam logic [7:0] CH_D9     = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LFHEX  = 8'h66;

	localparam logic [7:0] CTL_BEL = 8'd7;
	localparam logic [7:0] CTL_BS  = 8'd8;
	localparam logic [7:0] CTL_HT  = 8'd9;
	localparam logic [7:0] CTL_LF  = 8'd10;
	localparam logic [7:0] CTL_VT  = 8'd11;
	localparam logic [7:0] CTL_FF  = 8'd12;
	localparam logic [7:0] CTL_CR  = 8'd13;

	// APB register index (byte address bit 2 and up)
	localparam logic REG_OVF_VALUE = 1'b0;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_NOHEX = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_HEXFIRST,
		PH_HEX,
		PH_HEXPFX,
		PH_OCT
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] val;
	} esc_map_t;

	function automatic digit_t hex_digit(input logic [7:0] b);
		digit_t r;
		r.ok  = 1'b0;
		r.val = '0;
		if (b >= CH_D0 && b <= CH_D9) begin
			r.ok  = 1'b1;
			r.val = b[3:0];
		end else if ((b >= CH_LA && b <= CH_LFHEX) || (b >= CH_UA && b <= CH_UF)) begin
			r.ok  = 1'b1;
			r.val = 4'(b[2:0] + 3'd1) + 4'd8;
		end
		return r;
	endfunction

	function automatic logic is_oct(input logic [7:0] b);
		return b[7:3] == CH_D0[7:3];
	endfunction

	function automatic esc_map_t esc_map(input logic [7:0] b);
		esc_map_t r;
		r.hit = 1'b1;
		unique case (b)
			CH_LA:     r.val = CTL_BEL;
			CH_LB:     r.val = CTL_BS;
			CH_LF:     r.val = CTL_FF;
			CH_LN:     r.val = CTL_LF;
			CH_LR:     r.val = CTL_CR;
			CH_LT:     r.val = CTL_HT;
			CH_LV:     r.val = CTL_VT;
			CH_BSLASH: r.val = CH_BSLASH;
			default: begin
				r.hit = 1'b0;
				r.val = b;
			end
		endcase
		return r;
	endfunction

endpackage

// File: src/cedc_if.sv
interface cedc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_req;

	modport source (output valid, output in_byte, output start_req, input ready);
	modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface cedc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  char_value;
	logic [15:0] consumed;
	logic [1:0]  status;

	modport source (output valid, output char_value, output consumed, output status,
		input ready);
	modport sink   (input valid, input char_value, input consumed, input status,
		output ready);
endinterface

// File: src/c_escape_char_decoder_unit.sv
// Channel  Dir  Payload                              Handshake
// din      in   in_byte[7:0], start_req              valid/ready
// dout     out  char_value[7:0], consumed[15:0],     valid/ready
//               status[1:0]
// apb      in   overflow_value at byte address 0     psel/penable/pwrite, pready=1
//
// One byte per cycle sustained while dout is not stalled; the byte ending the parse passes
// through the input register, then the result register loads its transaction.
// The parse state is updated by combinational logic from the input register.
// arst_n clears the parse state and both valid flags; overflow_value returns to 127.
// A stalled dout holds its transaction while one more byte waits in the input register.
module c_escape_char_decoder_unit
	import cedc_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cedc_in_if.sink     din,
	cedc_out_if.source  dout,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] overflow_value;

	cedc_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.overflow_value (overflow_value)
	);

	cedc_parse_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.din            (din),
		.dout           (dout),
		.overflow_value (overflow_value)
	);

endmodule

// File: src/cedc_cfg_regs.sv
module cedc_cfg_regs
	import cedc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  overflow_value
);

	logic [7:0] ovf_value_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_OVF_VALUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_value_q <= OVF_VALUE_RST;
		end else if (wr_en) begin
			ovf_value_q <= pwdata[7:0];
		end
	end

	assign prdata         = (paddr[2] == REG_OVF_VALUE) ? {24'd0, ovf_value_q} : 32'd0;
	assign overflow_value = ovf_value_q;

endmodule

// File: src/cedc_parse_core.sv
`include "assert_macros.svh"

module cedc_parse_core
	import cedc_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	cedc_in_if.sink           din,
	cedc_out_if.source        dout,
	input  logic [7:0]        overflow_value
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       advance;

	// parse state
	phase_t                phase_q, phase_d;
	logic [7:0]            accum_q, accum_d;
	logic                  ovf_q, ovf_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic                  hsz_q, hsz_d;

	// result register
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic [15:0] consumed_q;
	status_t     status_q;

	logic                  emit;
	logic [7:0]            e_val;
	logic [COUNT_BITS-1:0] e_cnt;
	status_t               e_st;
	logic [15:0]           e_cnt_sat;

	logic [COUNT_BITS-1:0] cnt_inc, cnt_inc2;
	digit_t                hd;
	esc_map_t              em;
	logic [11:0]           hex_sum, oct_sum;

	assign advance   = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			byte_s1  <= din.in_byte;
			start_s1 <= din.start_req;
		end
	end

	assign cnt_inc  = (count_q == CNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
	assign cnt_inc2 = (cnt_inc == CNT_MAX) ? cnt_inc : cnt_inc + COUNT_BITS'(1);
	assign hd       = hex_digit(byte_s1);
	assign em       = esc_map(byte_s1);
	assign hex_sum  = {accum_q, 4'd0} + {8'd0, hd.val};
	assign oct_sum  = {1'b0, accum_q, 3'd0} + {9'd0, byte_s1[2:0]};

	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		ovf_d   = ovf_q;
		count_d = count_q;
		hsz_d   = hsz_q;
		emit    = 1'b0;
		e_val   = byte_s1;
		e_cnt   = cnt_inc;
		e_st    = STAT_OK;
		if (start_s1) begin
			accum_d = '0;
			ovf_d   = 1'b0;
			hsz_d   = 1'b0;
			phase_d = PH_IDLE;
			if (byte_s1 == CH_NUL) begin
				count_d = '0;
				emit    = 1'b1;
				e_val   = '0;
				e_cnt   = '0;
			end else begin
				count_d = COUNT_BITS'(1);
				e_cnt   = COUNT_BITS'(1);
				if (byte_s1 == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else begin
					emit = 1'b1;
				end
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_ESC: begin
					count_d = cnt_inc;
					if (byte_s1 == CH_LX) begin
						phase_d = PH_HEXFIRST;
					end else if (!em.hit && is_oct(byte_s1)) begin
						accum_d = {5'd0, byte_s1[2:0]};
						ovf_d   = 1'b0;
						phase_d = PH_OCT;
					end else begin
						emit  = 1'b1;
						e_val = em.val;
					end
				end
				PH_HEXFIRST: begin
					if (!hd.ok) begin
						emit  = 1'b1;
						e_val = '0;
						e_cnt = '0;
						e_st  = STAT_NOHEX;
					end else begin
						count_d = cnt_inc;
						accum_d = {4'd0, hd.val};
						ovf_d   = 1'b0;
						hsz_d   = (hd.val == 4'd0);
						phase_d = PH_HEX;
					end
				end
				PH_HEX: begin
					hsz_d = 1'b0;
					if (hsz_q && (byte_s1 == CH_LX || byte_s1 == CH_UX)) begin
						phase_d = PH_HEXPFX;
					end else if (!hd.ok) begin
						emit  = 1'b1;
						e_cnt = count_q;
						e_val = ovf_q ? overflow_value : accum_q;
						e_st  = ovf_q ? STAT_RANGE : STAT_OK;
					end else begin
						accum_d = hex_sum[7:0];
						ovf_d   = ovf_q || (hex_sum[11:8] != 4'd0);
						count_d = cnt_inc;
					end
				end
				PH_HEXPFX: begin
					if (!hd.ok) begin
						emit  = 1'b1;
						e_val = '0;
						e_cnt = count_q;
					end else begin
						count_d = cnt_inc2;
						accum_d = {4'd0, hd.val};
						phase_d = PH_HEX;
					end
				end
				PH_OCT: begin
					if (is_oct(byte_s1)) begin
						accum_d = oct_sum[7:0];
						ovf_d   = ovf_q || (oct_sum[11:8] != 4'd0);
						count_d = cnt_inc;
					end else begin
						emit  = 1'b1;
						e_cnt = count_q;
						e_val = ovf_q ? overflow_value : accum_q;
						e_st  = ovf_q ? STAT_RANGE : STAT_OK;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		if (emit) begin
			phase_d = PH_IDLE;
		end
	end

	generate
		if (COUNT_BITS > 16) begin : g_sat
			assign e_cnt_sat = (|e_cnt[COUNT_BITS-1:16]) ? 16'hFFFF : e_cnt[15:0];
		end else begin : g_ext
			assign e_cnt_sat = 16'(e_cnt);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			accum_q <= '0;
			ovf_q   <= 1'b0;
			count_q <= '0;
			hsz_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			ovf_q   <= ovf_d;
			count_q <= count_d;
			hsz_q   <= hsz_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			char_q     <= e_val;
			consumed_q <= e_cnt_sat;
			status_q   <= e_st;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.char_value = char_q;
	assign dout.consumed   = consumed_q;
	assign dout.status     = status_q;

	`ASSERT_NEXT(a_plain_start_emits, clk, arst_n,
		advance && start_s1 && byte_s1 != CH_BSLASH, out_valid_q && phase_q == PH_IDLE,
		"plain start byte gave no transaction")
	`ASSERT_IMPL(a_nohex_shape, clk, arst_n,
		out_valid_q && status_q == STAT_NOHEX, char_q == 8'd0 && consumed_q == 16'd0,
		"hex-without-digits transaction carries value or count")
	`ASSERT_IMPL(a_hsz_only_in_hex, clk, arst_n,
		hsz_q, phase_q == PH_HEX && accum_q == 8'd0,
		"leading-zero flag set outside a hex digit run")

endmodule

// File: tb/c_escape_char_decoder_unit_test.sv
`timescale 1ns / 100ps

module c_escape_char_decoder_unit_test;
	import cedc_pkg::*;

	localparam int CNT_BITS     = 16;
	localparam int CLK_HALF     = 5;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_CYC   = 8;
	localparam int HOLD_CYC     = 400;
	localparam int CHUNK_BYTES  = 370;
	localparam int LONG_DIGITS  = 40;

	typedef struct packed {
		logic [7:0] b;
		logic       st;
		logic       counted;
	} text_byte_t;

	class escape_scoreboard;
		typedef struct {
			logic [7:0]  ch;
			logic [15:0] cnt;
			status_t     st;
		} decoded_t;

		decoded_t              decoded_q[$];
		phase_t                ph;
		logic [7:0]            acc;
		bit                    ovf;
		logic [CNT_BITS-1:0]   cnt;
		bit                    hex_zero;
		logic [7:0]            ovf_value;
		int                    errors;
		int                    results;

		function new();
			ovf_value = OVF_VALUE_RST;
			ph        = PH_IDLE;
			acc       = '0;
			ovf       = 0;
			cnt       = '0;
			hex_zero  = 0;
			errors    = 0;
			results   = 0;
		endfunction

		function int hex_val(logic [7:0] b);
			if (b >= CH_D0 && b <= CH_D9)
				return int'(b - CH_D0);
			if (b >= CH_LA && b <= CH_LFHEX)
				return int'(b - CH_LA) + 10;
			if (b >= CH_UA && b <= CH_UF)
				return int'(b - CH_UA) + 10;
			return -1;
		endfunction

		function bit is_octal(logic [7:0] b);
			return b >= CH_D0 && b < CH_D0 + 8'd8;
		endfunction

		function void bump();
			if (cnt != '1)
				cnt++;
		endfunction

		function void add_digit(int base, int d);
			int t;
			t = int'(acc) * base + d;
			if (t > 255)
				ovf = 1;
			acc = t[7:0];
		endfunction

		function void emit(logic [7:0] v, logic [CNT_BITS-1:0] c, status_t s);
			decoded_t e;
			e.ch  = v;
			e.cnt = (c > 65535) ? 16'hFFFF : 16'(c);
			e.st  = s;
			decoded_q.push_back(e);
			ph = PH_IDLE;
		endfunction

		function void finish_number();
			if (ovf)
				emit(ovf_value, cnt, STAT_RANGE);
			else
				emit(acc, cnt, STAT_OK);
		endfunction

		// accepted input transaction
		function void note(logic [7:0] b, logic st);
			int d;
			if (st) begin
				acc      = '0;
				ovf      = 0;
				hex_zero = 0;
				cnt      = '0;
				ph       = PH_IDLE;
				if (b == CH_NUL) begin
					emit(8'd0, '0, STAT_OK);
					return;
				end
				bump();
				if (b == CH_BSLASH)
					ph = PH_ESC;
				else
					emit(b, cnt, STAT_OK);
				return;
			end
			case (ph)
				PH_ESC: begin
					bump();
					case (b)
						CH_LA:     emit(CTL_BEL, cnt, STAT_OK);
						CH_LB:     emit(CTL_BS, cnt, STAT_OK);
						CH_LF:     emit(CTL_FF, cnt, STAT_OK);
						CH_LN:     emit(CTL_LF, cnt, STAT_OK);
						CH_LR:     emit(CTL_CR, cnt, STAT_OK);
						CH_LT:     emit(CTL_HT, cnt, STAT_OK);
						CH_LV:     emit(CTL_VT, cnt, STAT_OK);
						CH_BSLASH: emit(CH_BSLASH, cnt, STAT_OK);
						CH_LX:     ph = PH_HEXFIRST;
						default: begin
							if (is_octal(b)) begin
								acc = b - CH_D0;
								ovf = 0;
								ph  = PH_OCT;
							end else begin
								emit(b, cnt, STAT_OK);
							end
						end
					endcase
				end
				PH_HEXFIRST: begin
					d = hex_val(b);
					if (d < 0) begin
						emit(8'd0, '0, STAT_NOHEX);
					end else begin
						bump();
						acc      = d[7:0];
						ovf      = 0;
						hex_zero = (d == 0);
						ph       = PH_HEX;
					end
				end
				PH_HEX: begin
					if (hex_zero && (b == CH_LX || b == CH_UX)) begin
						hex_zero = 0;
						ph       = PH_HEXPFX;
					end else begin
						hex_zero = 0;
						d = hex_val(b);
						if (d < 0) begin
							finish_number();
						end else begin
							add_digit(16, d);
							bump();
						end
					end
				end
				PH_HEXPFX: begin
					d = hex_val(b);
					if (d < 0) begin
						emit(8'd0, cnt, STAT_OK);
					end else begin
						bump();
						bump();
						acc = d[7:0];
						ph  = PH_HEX;
					end
				end
				PH_OCT: begin
					if (is_octal(b)) begin
						add_digit(8, int'(b - CH_D0));
						bump();
					end else begin
						finish_number();
					end
				end
				default: ph = PH_IDLE;
			endcase
		endfunction

		function void check(logic [7:0] ch, logic [15:0] c, logic [1:0] st);
			decoded_t e;
			results++;
			if (decoded_q.size() == 0) begin
				$error("unexpected result: char_value=%0d consumed=%0d status=%0d", ch, c, st);
				errors++;
				return;
			end
			e = decoded_q.pop_front();
			if (ch !== e.ch) begin
				$error("char_value: expected %0d, actual %0d", e.ch, ch);
				errors++;
			end
			if (c !== e.cnt) begin
				$error("consumed: expected %0d, actual %0d", e.cnt, c);
				errors++;
			end
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cedc_in_if  din_ch ();
	cedc_out_if dout_ch ();

	c_escape_char_decoder_unit #(
		.COUNT_BITS(CNT_BITS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	escape_scoreboard sb;
	text_byte_t       stim_q[$];
	bit               quiet;
	bit               hold_req;
	int               hold_left;
	int               cycle_cnt;
	int               bytes_sent;
	int               noise_sent;
	int               cfg_writes;

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stalls unless quiet, plus one long hold-off on request
	initial begin
		dout_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 0;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_ch.ready <= 1'b0;
			end else if (quiet) begin
				dout_ch.ready <= 1'b1;
			end else begin
				dout_ch.ready <= ($urandom_range(99) >= 25);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout_ch.valid && dout_ch.ready)
			sb.check(dout_ch.char_value, dout_ch.consumed, dout_ch.status);
	end

	function automatic void push(logic [7:0] b, logic st, logic counted = 1'b1);
		text_byte_t t;
		t.b       = b;
		t.st      = st;
		t.counted = counted;
		stim_q.push_back(t);
	endfunction

	task automatic send_byte(input text_byte_t t);
		if (!quiet) begin
			while ($urandom_range(99) < 25) begin
				@(negedge clk);
				din_ch.valid   <= 1'b0;
				din_ch.in_byte <= 8'($urandom);
			end
		end
		@(negedge clk);
		din_ch.valid     <= 1'b1;
		din_ch.in_byte   <= t.b;
		din_ch.start_req <= t.st;
		@(posedge clk);
		while (!din_ch.ready)
			@(posedge clk);
		sb.note(t.b, t.st);
		if (t.counted)
			bytes_sent++;
		else
			noise_sent++;
	endtask

	task automatic flush_stim();
		text_byte_t t;
		while (stim_q.size() > 0) begin
			t = stim_q.pop_front();
			send_byte(t);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		din_ch.valid <= 1'b0;
		while (sb.decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_OVF_VALUE, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_overflow_value(input logic [7:0] v);
		logic [31:0] rd;
		apb_access(1'b1, {24'd0, v}, rd);
		sb.ovf_value = v;
		cfg_writes++;
		apb_access(1'b0, 32'd0, rd);
		if (rd[7:0] !== v) begin
			$error("overflow_value readback: expected %0d, actual %0d", v, rd[7:0]);
			sb.errors++;
		end
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(21);
		if (v < 10)
			return CH_D0 + 8'(v);
		if (v < 16)
			return CH_LA + 8'(v - 10);
		return CH_UA + 8'(v - 16);
	endfunction

	function automatic logic [7:0] simple_esc();
		case ($urandom_range(7))
			0: return CH_LA;
			1: return CH_LB;
			2: return CH_LF;
			3: return CH_LN;
			4: return CH_LR;
			5: return CH_LT;
			6: return CH_LV;
			default: return CH_BSLASH;
		endcase
	endfunction

	function automatic void gen_random_seq();
		int r;
		int n;
		r = $urandom_range(99);
		if (r < 10) begin
			push(8'($urandom), 1'b1);
		end else if (r < 25) begin
			push(CH_BSLASH, 1'b1);
			push(simple_esc(), 1'b0);
		end else if (r < 50) begin
			push(CH_BSLASH, 1'b1);
			push(CH_LX, 1'b0);
			if ($urandom_range(4) == 0) begin
				push(CH_D0, 1'b0);
				push($urandom_range(1) ? CH_LX : CH_UX, 1'b0);
			end
			n = $urandom_range(4);
			repeat (n) push(hex_char(), 1'b0);
			push(8'($urandom), 1'b0);
		end else if (r < 75) begin
			push(CH_BSLASH, 1'b1);
			n = $urandom_range(5, 1);
			repeat (n) push(CH_D0 + 8'($urandom_range(7)), 1'b0);
			push(8'($urandom), 1'b0);
		end else if (r < 85) begin
			push(CH_BSLASH, 1'b1);
			push(8'($urandom), 1'b0);
		end else if (r < 93) begin
			// cut short; the next start drops it
			push(CH_BSLASH, 1'b1);
			if ($urandom_range(1)) begin
				push(CH_LX, 1'b0);
				n = $urandom_range(2);
				repeat (n) push(hex_char(), 1'b0);
			end else begin
				n = $urandom_range(3);
				repeat (n) push(CH_D0 + 8'($urandom_range(7)), 1'b0);
			end
		end else begin
			n = $urandom_range(3, 1);
			repeat (n) push(8'($urandom), 1'b0, 1'b0);
		end
		if ($urandom_range(9) == 0)
			push(8'($urandom), 1'b0, 1'b0);
	endfunction

	task automatic random_chunk(input int target);
		int start_cnt;
		start_cnt = bytes_sent;
		while (bytes_sent - start_cnt < target) begin
			gen_random_seq();
			flush_stim();
		end
	endtask

	initial begin
		int k;
		sb         = new();
		quiet      = 0;
		hold_req   = 0;
		cycle_cnt  = 0;
		bytes_sent = 0;
		noise_sent = 0;
		cfg_writes = 0;
		arst_n           = 1'b0;
		din_ch.valid     = 1'b0;
		din_ch.in_byte   = '0;
		din_ch.start_req = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed cases under the reset overflow value
		push(CH_NUL, 1'b1);
		push(8'hFF, 1'b1);
		push(8'h55, 1'b0, 1'b0);
		push(CH_BSLASH, 1'b1); push(CH_LA, 1'b0);
		push(CH_BSLASH, 1'b1); push(CH_LV, 1'b0);
		push(CH_BSLASH, 1'b1); push(CH_BSLASH, 1'b0);
		push(CH_BSLASH, 1'b1); push(CH_LX, 1'b0); push(8'h67, 1'b0);
		push(CH_BSLASH, 1'b1); push(CH_LX, 1'b0); push(CH_D0, 1'b0);
		push(CH_LX, 1'b0); push(8'h3B, 1'b0);
		push(CH_BSLASH, 1'b1); push(CH_NUL, 1'b0);
		push(CH_BSLASH, 1'b1); push(8'h37, 1'b0); push(8'h37, 1'b0);
		push(8'h37, 1'b0); push(8'h20, 1'b0);
		push(CH_BSLASH, 1'b1); push(CH_LX, 1'b0); push(8'h31, 1'b0);
		push(CH_BSLASH, 1'b1); push(8'hC8, 1'b0);
		flush_stim();
		drain();

		set_overflow_value(8'd0);
		push(CH_BSLASH, 1'b1); push(CH_UX, 1'b0);
		push(CH_BSLASH, 1'b1); push(CH_LX, 1'b0); push(8'h31, 1'b0);
		push(CH_D0, 1'b0); push(CH_D0, 1'b0); push(8'h80, 1'b0);
		flush_stim();
		drain();

		// long octal run that overflows early and stays overflowed
		set_overflow_value(8'd255);
		push(CH_BSLASH, 1'b1);
		flush_stim();
		for (k = 0; k < LONG_DIGITS; k++) begin
			push(CH_D0 + 8'(k == 5 ? 1 : 0), 1'b0);
			flush_stim();
		end
		push(8'h7A, 1'b0);
		push(CH_BSLASH, 1'b1); push(8'h34, 1'b0); push(8'h30, 1'b0);
		push(8'h30, 1'b0); push(8'h3B, 1'b0);
		flush_stim();
		drain();

		set_overflow_value(8'($urandom));
		hold_req = 1;
		random_chunk(CHUNK_BYTES);
		drain();

		set_overflow_value(8'd255);
		quiet = 1;
		random_chunk(CHUNK_BYTES);
		quiet = 0;
		drain();

		set_overflow_value(8'd0);
		random_chunk(CHUNK_BYTES);
		drain();

		set_overflow_value(8'($urandom));
		random_chunk(CHUNK_BYTES);
		drain();

		$display("Run covered %0d input bytes (%0d ignored) and %0d checked results,",
			bytes_sent, noise_sent, sb.results);
		$display("with %0d overflow_value settings and a long overflowing octal run.",
			cfg_writes);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
